### hw/rtl/scau_pkg.sv
// Shared types and constants for the scanline cost aggregation unit.
// Depends on nothing; the top level, the front and the back import it.
package scau_pkg;

    localparam int COST_W           = 16;
    localparam int COLOR_W          = 24;
    localparam int DIST_W           = 8;
    localparam int COUNT_REG_W      = 7;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 16;
    localparam int DEFAULT_MAX_DISP = 64;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [COST_W-1:0] COST_ALL_ONES = '1;

    localparam logic [CFG_INDEX_W-1:0] CFG_DISPARITY_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PENALTY_ONE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PENALTY_TWO     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_THRESHOLD = 3'd3;

    localparam logic [COUNT_REG_W-1:0] RESET_DISPARITY_COUNT = 7'd64;
    localparam logic [COST_W-1:0]      RESET_PENALTY_ONE     = 16'd160;
    localparam logic [COST_W-1:0]      RESET_PENALTY_TWO     = 16'd960;
    localparam logic [DIST_W-1:0]      RESET_COLOR_THRESHOLD = 8'd15;

    // Number of color distances below the threshold.
    localparam logic [1:0] BELOW_NONE = 2'd0;
    localparam logic [1:0] BELOW_ONE  = 2'd1;
    localparam logic [1:0] BELOW_BOTH = 2'd2;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x.
    localparam logic [15:0] TENTH_MULT  = 16'd52429;
    localparam int          TENTH_SHIFT = 19;

    typedef struct packed {
        logic [COUNT_REG_W-1:0] disparity_count;
        logic [COST_W-1:0]      penalty_one;
        logic [COST_W-1:0]      penalty_two;
        logic [DIST_W-1:0]      color_threshold;
    } cfg_t;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              first;
        logic [1:0]        below;
        logic              last;
    } item_t;

endpackage

### hw/rtl/scanline_cost_aggregation_unit.sv
// Scanline cost aggregation unit: one beat in and one beat out per cycle while out_ready
// holds. An accepted beat waits in the queue, then moves into the path memory read, and
// the result is then registered in the output register.
// A one-entry bypass of the path memory write keeps that rate.
// Reset clears control state and restores register defaults; the path memory is not
// cleared and holds undefined data until a line start writes it.
module scanline_cost_aggregation_unit
    import scau_pkg::*;
#(
    parameter int MAX_DISP = DEFAULT_MAX_DISP
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COST_W-1:0]      cost,
    input  logic [COLOR_W-1:0]     left_color,
    input  logic [COLOR_W-1:0]     right_color,
    input  logic [COLOR_W-1:0]     right_prev_color,
    input  logic                   right_valid,
    input  logic                   line_start,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COST_W-1:0]      aggregated_cost,
    output logic                   pixel_last
);

    localparam int IDXW = $clog2(MAX_DISP);
    localparam int QW   = $bits(item_t) + IDXW;

    cfg_t            cfg_reg;
    logic            push_valid;
    logic            push_ready;
    item_t           push_item;
    logic [IDXW-1:0] push_idx;
    logic            pop_valid;
    logic            pop_ready;
    logic [QW-1:0]   pop_data;
    item_t           pop_item;
    logic [IDXW-1:0] pop_idx;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.disparity_count <= RESET_DISPARITY_COUNT;
            cfg_reg.penalty_one     <= RESET_PENALTY_ONE;
            cfg_reg.penalty_two     <= RESET_PENALTY_TWO;
            cfg_reg.color_threshold <= RESET_COLOR_THRESHOLD;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DISPARITY_COUNT: cfg_reg.disparity_count <= cfg_data[COUNT_REG_W-1:0];
                CFG_PENALTY_ONE:     cfg_reg.penalty_one     <= cfg_data;
                CFG_PENALTY_TWO:     cfg_reg.penalty_two     <= cfg_data;
                CFG_COLOR_THRESHOLD: cfg_reg.color_threshold <= cfg_data[DIST_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    scau_front #(
        .MAX_DISP(MAX_DISP)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cost            (cost),
        .left_color      (left_color),
        .right_color     (right_color),
        .right_prev_color(right_prev_color),
        .right_valid     (right_valid),
        .line_start      (line_start),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_item       (push_item),
        .push_idx        (push_idx)
    );

    scau_fifo #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data ({push_item, push_idx}),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data)
    );

    assign pop_item = pop_data[QW-1:IDXW];
    assign pop_idx  = pop_data[IDXW-1:0];

    scau_back #(
        .MAX_DISP(MAX_DISP)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_item       (pop_item),
        .pop_idx        (pop_idx),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .aggregated_cost(aggregated_cost),
        .pixel_last     (pixel_last)
    );

endmodule

### hw/rtl/scau_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module scau_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/scau_fifo.sv
// Short queue between the front and the back of the aggregation unit.
// Depends on nothing; the payload is a plain bit vector.
module scau_fifo #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/scau_front.sv
// Front of the aggregation unit: accepts beats, tracks the disparity index,
// computes color distances and penalty class. Depends on scau_pkg.
module scau_front
    import scau_pkg::*;
#(
    parameter int MAX_DISP = DEFAULT_MAX_DISP
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cfg_t                        cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [COST_W-1:0]           cost,
    input  logic [COLOR_W-1:0]          left_color,
    input  logic [COLOR_W-1:0]          right_color,
    input  logic [COLOR_W-1:0]          right_prev_color,
    input  logic                        right_valid,
    input  logic                        line_start,
    output logic                        push_valid,
    input  logic                        push_ready,
    output item_t                       push_item,
    output logic [$clog2(MAX_DISP)-1:0] push_idx
);

    localparam int IDXW = $clog2(MAX_DISP);
    localparam int CW   = $clog2(MAX_DISP + 1);
    localparam int W    = (CW > COUNT_REG_W) ? CW : COUNT_REG_W;

    function automatic logic [DIST_W-1:0] chan_diff(input logic [DIST_W-1:0] a,
                                                    input logic [DIST_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [DIST_W-1:0] color_dist(input logic [COLOR_W-1:0] a,
                                                     input logic [COLOR_W-1:0] b);
        logic [DIST_W-1:0] m;
        logic [DIST_W-1:0] g;
        logic [DIST_W-1:0] r;
        m = chan_diff(a[7:0], b[7:0]);
        g = chan_diff(a[15:8], b[15:8]);
        r = chan_diff(a[23:16], b[23:16]);
        if (g > m)
        begin
            m = g;
        end
        if (r > m)
        begin
            m = r;
        end
        return m;
    endfunction

    logic [IDXW-1:0]    idx_reg;
    logic [IDXW-1:0]    idx_next;
    logic               first_reg;
    logic               first_next;
    logic [COLOR_W-1:0] prev_left_reg;
    logic [COLOR_W-1:0] prev_left_next;
    logic [DIST_W-1:0]  left_dist_reg;
    logic [DIST_W-1:0]  left_dist_next;
    logic [DIST_W-1:0]  right_dist_reg;
    logic [DIST_W-1:0]  right_dist_next;

    logic [W-1:0]    count_ext;
    logic [W-1:0]    count;
    logic [IDXW-1:0] d;
    logic            last;
    logic            accept;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    always_comb
    begin
        count_ext = W'(cfg.disparity_count);
        if (count_ext == '0)
        begin
            count = W'(1);
        end
        else if (count_ext > W'(MAX_DISP))
        begin
            count = W'(MAX_DISP);
        end
        else
        begin
            count = count_ext;
        end

        d    = (W'(idx_reg) >= count) ? '0 : idx_reg;
        last = (W'(d) + W'(1)) >= count;

        first_next      = first_reg;
        prev_left_next  = prev_left_reg;
        left_dist_next  = left_dist_reg;
        right_dist_next = right_dist_reg;
        if (d == '0)
        begin
            first_next      = line_start;
            left_dist_next  = line_start ? '0 : color_dist(left_color, prev_left_reg);
            prev_left_next  = left_color;
            right_dist_next = left_dist_next;
        end
        if (right_valid)
        begin
            right_dist_next = color_dist(right_color, right_prev_color);
        end

        idx_next = last ? '0 : d + 1'b1;

        push_item.cost  = cost;
        push_item.first = first_next;
        push_item.below = {1'b0, left_dist_next < cfg.color_threshold}
                        + {1'b0, right_dist_next < cfg.color_threshold};
        push_item.last  = last;
        push_idx        = d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            first_reg      <= 1'b1;
            prev_left_reg  <= '0;
            left_dist_reg  <= '0;
            right_dist_reg <= '0;
        end
        else if (accept)
        begin
            idx_reg        <= idx_next;
            first_reg      <= first_next;
            prev_left_reg  <= prev_left_next;
            left_dist_reg  <= left_dist_next;
            right_dist_reg <= right_dist_next;
        end
    end

endmodule

### hw/rtl/scau_back.sv
// Back of the aggregation unit: reads the path memory, forms the path
// minimum and drives the output register. Depends on scau_pkg and scau_ram.
module scau_back
    import scau_pkg::*;
#(
    parameter int MAX_DISP = DEFAULT_MAX_DISP
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cfg_t                        cfg,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  item_t                       pop_item,
    input  logic [$clog2(MAX_DISP)-1:0] pop_idx,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [COST_W-1:0]           aggregated_cost,
    output logic                        pixel_last
);

    localparam int IDXW = $clog2(MAX_DISP);

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? COST_ALL_ONES : s[COST_W-1:0];
    endfunction

    function automatic logic [COST_W-1:0] min2(input logic [COST_W-1:0] a,
                                               input logic [COST_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    logic [COST_W-1:0] p1_quarter_reg;
    logic [COST_W-1:0] p2_quarter_reg;
    logic [COST_W-1:0] p1_tenth_reg;
    logic [COST_W-1:0] p2_tenth_reg;
    logic [31:0]       p1_prod;
    logic [31:0]       p2_prod;

    logic              s1_valid_reg;
    item_t             s1_item_reg;
    logic [IDXW-1:0]   s1_idx_reg;
    logic              byp_valid_reg;
    logic [IDXW-1:0]   byp_addr_reg;
    logic [COST_W-1:0] byp_data_reg;
    logic [COST_W-1:0] lower_reg;
    logic [COST_W-1:0] run_min_reg;
    logic [COST_W-1:0] prev_min_reg;
    logic              out_valid_reg;
    logic [COST_W-1:0] out_cost_reg;
    logic              out_last_reg;

    logic              adv;
    logic              pop;
    logic              commit;
    logic [IDXW-1:0]   upper_addr;
    logic [IDXW-1:0]   s1_upper_addr;
    logic [COST_W-1:0] rdata_center;
    logic [COST_W-1:0] rdata_upper;
    logic              d0;
    logic [COST_W-1:0] center;
    logic [COST_W-1:0] upper;
    logic [COST_W-1:0] lower;
    logic [COST_W-1:0] p1;
    logic [COST_W-1:0] p2;
    logic [COST_W-1:0] m;
    logic [COST_W:0]   sum;
    logic [COST_W-1:0] res;
    logic [COST_W-1:0] run_min_eff;
    logic [COST_W-1:0] run_min_new;

    assign adv       = !out_valid_reg || out_ready;
    assign pop_ready = adv;
    assign pop       = pop_valid && adv;
    assign commit    = s1_valid_reg && adv;

    assign upper_addr    = pop_idx + 1'b1;
    assign s1_upper_addr = s1_idx_reg + 1'b1;

    assign p1_prod = {16'd0, cfg.penalty_one} * {16'd0, TENTH_MULT};
    assign p2_prod = {16'd0, cfg.penalty_two} * {16'd0, TENTH_MULT};

    always_ff @(posedge clk)
    begin
        p1_quarter_reg <= {2'b00, cfg.penalty_one[COST_W-1:2]};
        p2_quarter_reg <= {2'b00, cfg.penalty_two[COST_W-1:2]};
        p1_tenth_reg   <= COST_W'(p1_prod >> TENTH_SHIFT);
        p2_tenth_reg   <= COST_W'(p2_prod >> TENTH_SHIFT);
    end

    scau_ram #(
        .WIDTH(COST_W),
        .DEPTH(MAX_DISP)
    ) u_ram_center (
        .clk  (clk),
        .we   (commit),
        .waddr(s1_idx_reg),
        .wdata(res),
        .re   (pop),
        .raddr(pop_idx),
        .rdata(rdata_center)
    );

    scau_ram #(
        .WIDTH(COST_W),
        .DEPTH(MAX_DISP)
    ) u_ram_upper (
        .clk  (clk),
        .we   (commit),
        .waddr(s1_idx_reg),
        .wdata(res),
        .re   (pop),
        .raddr(upper_addr),
        .rdata(rdata_upper)
    );

    always_comb
    begin
        d0     = (s1_idx_reg == '0);
        center = (byp_valid_reg && byp_addr_reg == s1_idx_reg) ? byp_data_reg : rdata_center;
        if (s1_item_reg.last)
        begin
            upper = COST_ALL_ONES;
        end
        else if (byp_valid_reg && byp_addr_reg == s1_upper_addr)
        begin
            upper = byp_data_reg;
        end
        else
        begin
            upper = rdata_upper;
        end
        lower = d0 ? COST_ALL_ONES : lower_reg;

        unique case (s1_item_reg.below)
            BELOW_BOTH:
            begin
                p1 = cfg.penalty_one;
                p2 = cfg.penalty_two;
            end
            BELOW_ONE:
            begin
                p1 = p1_quarter_reg;
                p2 = p2_quarter_reg;
            end
            default:
            begin
                p1 = p1_tenth_reg;
                p2 = p2_tenth_reg;
            end
        endcase

        m   = min2(min2(center, sat_add(lower, p1)),
                   min2(sat_add(upper, p1), sat_add(prev_min_reg, p2)));
        sum = {1'b0, s1_item_reg.cost} + {1'b0, m};
        res = s1_item_reg.first ? s1_item_reg.cost : sum[COST_W:1];

        run_min_eff = d0 ? COST_ALL_ONES : run_min_reg;
        run_min_new = min2(run_min_eff, res);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_item_reg <= pop_item;
            s1_idx_reg  <= pop_idx;
        end
        if (adv)
        begin
            byp_addr_reg <= s1_idx_reg;
            byp_data_reg <= res;
        end
        if (commit)
        begin
            out_cost_reg <= res;
            out_last_reg <= s1_item_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            lower_reg     <= COST_ALL_ONES;
            run_min_reg   <= COST_ALL_ONES;
            prev_min_reg  <= COST_ALL_ONES;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg  <= pop_valid;
                byp_valid_reg <= s1_valid_reg;
                out_valid_reg <= s1_valid_reg;
            end
            if (commit)
            begin
                lower_reg   <= center;
                run_min_reg <= run_min_new;
                if (s1_item_reg.last)
                begin
                    prev_min_reg <= run_min_new;
                end
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign aggregated_cost = out_cost_reg;
    assign pixel_last      = out_last_reg;

endmodule
